>>> design/dpf_pkg.sv
// ----------------------------------------------------------------------------
// dpf_pkg
// Shared constants for the decimal pair formatter: ascii codes and sizes.
// ----------------------------------------------------------------------------
package dpf_pkg;

	localparam int unsigned DefValueWidth = 32;
	localparam int unsigned PortWidth     = 32;
	localparam int unsigned CharWidth     = 7;

	localparam logic [CharWidth-1:0] CH_ZERO  = 7'h30;
	localparam logic [CharWidth-1:0] CH_COMMA = 7'h2C;
	localparam logic [CharWidth-1:0] CH_CR    = 7'h0D;
	localparam logic [CharWidth-1:0] CH_LF    = 7'h0A;

endpackage

>>> design/decimal_pair_formatter.sv
// ----------------------------------------------------------------------------
// decimal_pair_formatter
// Turns a pair of unsigned numbers into the ascii record "a,b\r\n", one
// character per output transaction, using a shared double-dabble unit.
// ----------------------------------------------------------------------------
//
//  channel  signals                                 direction
//  in       in_valid, in_stall, first_value,        value pair, one per record
//           second_value
//  out      out_valid, out_stall, char_byte,        one character per transaction
//           last_char
//
//  Each value is shifted through the shared double-dabble unit bit by bit, then
//  its digit slots are walked in order (leading zero skipped or character sent);
//  a character slot waits while the output register is stalled.
//  in_stall is high from acceptance until the line feed is loaded for output.
//  out_stall holds the output register and pauses character emission only.
//  arst_n clears the sequencer and the output valid; nothing else needs it.
//
module decimal_pair_formatter
	import dpf_pkg::*;
#(
	parameter int unsigned VALUE_WIDTH = DefValueWidth
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [PortWidth-1:0] first_value,
	input  logic [PortWidth-1:0] second_value,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [CharWidth-1:0] char_byte,
	output logic                 last_char
);

	localparam int unsigned DigN  = (VALUE_WIDTH * 30103) / 100000 + 1;
	localparam int unsigned BcdW  = 4 * DigN;
	localparam int unsigned CntW  = $clog2(VALUE_WIDTH + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CONV  = 3'd1;
	localparam logic [2:0] ST_EMIT  = 3'd2;
	localparam logic [2:0] ST_COMMA = 3'd3;
	localparam logic [2:0] ST_CR    = 3'd4;
	localparam logic [2:0] ST_LF    = 3'd5;

	logic [2:0]             state_q;
	logic                   phase_q;
	logic                   started_q;
	logic [CntW-1:0]        cnt_q;
	logic [VALUE_WIDTH-1:0] bin_q;
	logic [VALUE_WIDTH-1:0] second_q;
	logic [BcdW-1:0]        bcd_q;
	logic                   out_valid_q;
	logic [CharWidth-1:0]   char_q;
	logic                   last_q;

	logic [BcdW-1:0]        bcd_adj;
	logic [3:0]             top_digit;
	logic                   out_free;
	logic                   load_out;
	logic [2*PortWidth-1:0] first_ext;
	logic [2*PortWidth-1:0] second_ext;

	// double-dabble adjust, one layer per cycle
	always_comb begin
		bcd_adj = bcd_q;
		for (int i = 0; i < int'(DigN); i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end
		end
	end

	assign top_digit  = bcd_q[BcdW-1 -: 4];
	assign out_free   = !out_valid_q || !out_stall;
	assign first_ext  = {{PortWidth{1'b0}}, first_value};
	assign second_ext = {{PortWidth{1'b0}}, second_value};

	// a character enters the output register this cycle
	assign load_out = out_free && ((state_q == ST_EMIT &&
			!(!started_q && top_digit == 4'd0 && cnt_q != CntW'(1))) ||
			state_q == ST_COMMA || state_q == ST_CR || state_q == ST_LF);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= 1'b0;
			started_q   <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_CONV;
						phase_q <= 1'b0;
						cnt_q   <= CntW'(VALUE_WIDTH);
					end
				end
				ST_CONV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CntW'(1)) begin
						state_q   <= ST_EMIT;
						started_q <= 1'b0;
						cnt_q     <= CntW'(DigN);
					end
				end
				ST_EMIT: begin
					if (!started_q && top_digit == 4'd0 && cnt_q != CntW'(1)) begin
						cnt_q <= cnt_q - 1'b1;
					end else if (out_free) begin
						started_q   <= 1'b1;
						cnt_q       <= cnt_q - 1'b1;
						if (cnt_q == CntW'(1)) begin
							state_q <= phase_q ? ST_CR : ST_COMMA;
						end
					end
				end
				ST_COMMA: begin
					if (out_free) begin
						state_q     <= ST_CONV;
						phase_q     <= 1'b1;
						cnt_q       <= CntW'(VALUE_WIDTH);
					end
				end
				ST_CR: begin
					if (out_free) begin
						state_q     <= ST_LF;
					end
				end
				ST_LF: begin
					if (out_free) begin
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					bin_q    <= first_ext[VALUE_WIDTH-1:0];
					second_q <= second_ext[VALUE_WIDTH-1:0];
					bcd_q    <= '0;
				end
			end
			ST_CONV: begin
				bcd_q <= {bcd_adj[BcdW-2:0], bin_q[VALUE_WIDTH-1]};
				bin_q <= {bin_q[VALUE_WIDTH-2:0], 1'b0};
			end
			ST_EMIT: begin
				if (!started_q && top_digit == 4'd0 && cnt_q != CntW'(1)) begin
					bcd_q <= {bcd_q[BcdW-5:0], 4'b0};
				end else if (out_free) begin
					char_q <= CH_ZERO | {3'b000, top_digit};
					last_q <= 1'b0;
					bcd_q  <= {bcd_q[BcdW-5:0], 4'b0};
				end
			end
			ST_COMMA: begin
				if (out_free) begin
					char_q <= CH_COMMA;
					last_q <= 1'b0;
					bin_q  <= second_q;
					bcd_q  <= '0;
				end
			end
			ST_CR: begin
				if (out_free) begin
					char_q <= CH_CR;
					last_q <= 1'b0;
				end
			end
			ST_LF: begin
				if (out_free) begin
					char_q <= CH_LF;
					last_q <= 1'b1;
				end
			end
			default: begin
				bcd_q <= bcd_q;
			end
		endcase
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign char_byte = char_q;
	assign last_char = last_q;

	a_last_is_lf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_char |-> char_byte == CH_LF)
		else $error("last flag on a character other than line feed");

	a_accept_starts_conv: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == ST_CONV && !phase_q)
		else $error("accepted transaction did not start conversion");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(VALUE_WIDTH))
		else $error("sequencer count out of range");

	a_emit_cnt_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> cnt_q != '0)
		else $error("digit emission with no digits left");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the decimal pair formatter: directed value pairs
// from a table, then random pairs spread over all digit counts. Every character
// is checked against a queue filled from table text or an in-bench builder,
// while both channels idle and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top
	import dpf_pkg::*;
;

	localparam int unsigned ValueWidth  = DefValueWidth;
	localparam int          RandomPairs = 96;
	localparam int          DrainCycles = 120;
	localparam int          LongHoldAt  = 200;
	localparam int          LongHold    = 300;
	localparam int          DirCount    = 14;

	typedef struct packed {
		logic [CharWidth-1:0] code;
		logic                 last;
	} ascii_char_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [PortWidth-1:0] first_value;
	logic [PortWidth-1:0] second_value;
	logic                 out_valid;
	logic                 out_stall;
	logic [CharWidth-1:0] char_byte;
	logic                 last_char;

	ascii_char_t pending_chars[$];
	int          mismatches = 0;
	int          chars_taken = 0;

	logic [PortWidth-1:0] dir_first [DirCount] = '{
		32'd0, 32'd4294967295, 32'd0, 32'd4294967295, 32'd1, 32'd10, 32'd100,
		32'd999999999, 32'd2147483648, 32'h55555555, 32'h0000FFFF,
		32'd1234567890, 32'd5, 32'd42
	};
	logic [PortWidth-1:0] dir_second [DirCount] = '{
		32'd0, 32'd4294967295, 32'd4294967295, 32'd0, 32'd9, 32'd99, 32'd1000,
		32'd1000000000, 32'd2147483647, 32'hAAAAAAAA, 32'hFFFF0000,
		32'd987654321, 32'd50, 32'd0
	};
	// empty text: expected record comes from the record builder
	string dir_text [DirCount] = '{
		"0,0", "4294967295,4294967295", "0,4294967295", "4294967295,0", "1,9",
		"", "", "", "", "", "", "", "", ""
	};

	decimal_pair_formatter #(
		.VALUE_WIDTH(ValueWidth)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.first_value (first_value),
		.second_value(second_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.char_byte   (char_byte),
		.last_char   (last_char)
	);

	always #10 clk = ~clk;

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("mismatch at %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
		mismatches++;
	endtask

	function automatic void push_char(input logic [CharWidth-1:0] code, input logic last);
		ascii_char_t c;
		c.code = code;
		c.last = last;
		pending_chars.push_back(c);
	endfunction

	function automatic void push_decimal(input logic [PortWidth-1:0] raw);
		logic [PortWidth-1:0] v;
		logic [3:0]           digits[$];
		v = raw & ({PortWidth{1'b1}} >> (PortWidth - ValueWidth));
		if (v == '0) begin
			push_char(CH_ZERO, 1'b0);
			return;
		end
		while (v != '0) begin
			digits.push_front(4'(v % 10));
			v = v / 10;
		end
		foreach (digits[i])
			push_char(CH_ZERO + CharWidth'(digits[i]), 1'b0);
	endfunction

	function automatic void push_line_end();
		push_char(CH_CR, 1'b0);
		push_char(CH_LF, 1'b1);
	endfunction

	function automatic void build_record(input logic [PortWidth-1:0] a,
			input logic [PortWidth-1:0] b);
		push_decimal(a);
		push_char(CH_COMMA, 1'b0);
		push_decimal(b);
		push_line_end();
	endfunction

	function automatic void push_text_record(input string txt);
		byte ch;
		for (int i = 0; i < txt.len(); i++) begin
			ch = txt[i];
			push_char(ch[CharWidth-1:0], 1'b0);
		end
		push_line_end();
	endfunction

	function automatic logic [PortWidth-1:0] value_with_digits(input int ndig);
		longint unsigned lo;
		longint unsigned hi;
		lo = 1;
		for (int i = 1; i < ndig; i++)
			lo = lo * 10;
		hi = lo * 10 - 1;
		if (ndig == 1)
			lo = 0;
		if (hi > 64'hFFFFFFFF)
			hi = 64'hFFFFFFFF;
		return $urandom_range(PortWidth'(hi), PortWidth'(lo));
	endfunction

	// holds the offered pair until taken; valid stays high across back-to-back pairs
	task automatic send_pair(input logic [PortWidth-1:0] a, input logic [PortWidth-1:0] b,
			input string txt, input int idx);
		int gap;
		gap = ((idx / 24) % 3 == 1) ? 0 : $urandom_range(3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		first_value  <= a;
		second_value <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (txt.len() != 0)
			push_text_record(txt);
		else
			build_record(a, b);
	endtask

	initial begin
		logic [PortWidth-1:0] a;
		logic [PortWidth-1:0] b;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		first_value  = '0;
		second_value = '0;
		out_stall    = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DirCount; i++)
			send_pair(dir_first[i], dir_second[i], dir_text[i], i);

		for (int i = 0; i < RandomPairs; i++) begin
			if ($urandom_range(9) < 7) begin
				a = value_with_digits($urandom_range(10, 1));
				b = value_with_digits($urandom_range(10, 1));
			end else begin
				a = $urandom;
				b = $urandom;
			end
			send_pair(a, b, "", DirCount + i);
		end
		in_valid <= 1'b0;

		while (pending_chars.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// character sink with random hold-off and one long stall
	initial begin
		int          hold;
		ascii_char_t want;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (chars_taken == LongHoldAt)
				hold = LongHold;
			else if ((chars_taken / 60) % 3 == 2)
				hold = 0;
			else
				hold = $urandom_range(3);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!(out_valid && !out_stall))
				@(posedge clk);
			chars_taken++;
			if (pending_chars.size() == 0) begin
				report_mismatch("unexpected transaction, char_byte", 32'(char_byte), 0);
			end else begin
				want = pending_chars.pop_front();
				if (char_byte !== want.code)
					report_mismatch("char_byte", 32'(char_byte), 32'(want.code));
				if (last_char !== want.last)
					report_mismatch("last_char", 32'(last_char), 32'(want.last));
			end
		end
	end

	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

endmodule

>>> filelist.f
design/dpf_pkg.sv
design/decimal_pair_formatter.sv
tb/tb_top.sv
